/* design/swl_pkg.sv */
`default_nettype none

package swl_pkg;

    // Lattice geometry; the side must be a power of two no larger than 64.
    localparam int SIDE       = 64;
    localparam int COORD_W    = $clog2(SIDE);
    localparam int ADDR_W     = 3 * COORD_W;
    localparam int CELL_COUNT = SIDE * SIDE * SIDE;

    // Field widths.
    localparam int FIELD_COORD_W = 6;
    localparam int CELL_W        = 2;
    localparam int AXIS_W        = 2;
    localparam int RAND_W        = 16;
    localparam int PROB_W        = 17;
    localparam int COUNT_W       = 19;
    localparam int CFG_INDEX_W   = 2;
    localparam int SPECIES       = 4;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 80;

    // Cell species codes.
    localparam logic [CELL_W-1:0] CELL_EMPTY    = 2'd0;
    localparam logic [CELL_W-1:0] CELL_NUTRIENT = 2'd1;
    localparam logic [CELL_W-1:0] CELL_SOIL     = 2'd2;
    localparam logic [CELL_W-1:0] CELL_WORM     = 2'd3;

    // Item kinds carried on tuser.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Neighbour axis codes; any other code selects z.
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SOIL_FILL      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WORM_DEATH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPRODUCE      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUTRIENT_LEAVE = 2'd3;

    // Configuration reset values (probability scaled by 65536).
    localparam logic [PROB_W-1:0] SOIL_FILL_RESET      = 17'd32768;
    localparam logic [PROB_W-1:0] WORM_DEATH_RESET     = 17'd19661;
    localparam logic [PROB_W-1:0] REPRODUCE_RESET      = 17'd65536;
    localparam logic [PROB_W-1:0] NUTRIENT_LEAVE_RESET = 17'd65536;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic rd_nb;
        logic eval;
        logic commit;
    } swl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } swl_status_t;

endpackage

`default_nettype wire

/* design/swl_ctrl.sv */
`default_nettype none

module swl_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire swl_pkg::swl_status_t status,
    output swl_pkg::swl_cmd_t        cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RD_NB  = 3'd2;
    localparam logic [2:0] ST_EVAL   = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register; reset starts the clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_RD_NB;
                end
            end
            ST_RD_NB:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command decode.
    assign s_tready     = (state_reg == ST_IDLE);
    assign cmd.clear_wr = (state_reg == ST_CLEAR);
    assign cmd.accept   = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.rd_nb    = (state_reg == ST_RD_NB);
    assign cmd.eval     = (state_reg == ST_EVAL);
    assign cmd.commit   = (state_reg == ST_COMMIT) && status.out_free;

endmodule

`default_nettype wire

/* design/swl_dp.sv */
`default_nettype none

module swl_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Fields from bit 0 up: site_x, site_y, site_z, load_value, axis,
    // direction, rand_a, rand_b, one zero pad bit.
    input  wire logic [swl_pkg::IN_DATA_W-1:0]     s_tdata,
    // Field: cmd.
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Fields from bit 0 up: site_after, neighbour_after, count_empty,
    // count_nutrient, count_soil, count_worm.
    output logic [swl_pkg::OUT_DATA_W-1:0]         m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [swl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [swl_pkg::PROB_W-1:0]        cfg_wdata,
    input  wire swl_pkg::swl_cmd_t                 cmd,
    output swl_pkg::swl_status_t                   status
);

    localparam int CW = swl_pkg::COORD_W;
    localparam int AW = swl_pkg::ADDR_W;
    localparam int VW = swl_pkg::CELL_W;
    localparam int NW = swl_pkg::COUNT_W;
    localparam int PW = swl_pkg::PROB_W;
    localparam int RW = swl_pkg::RAND_W;
    localparam int FW = swl_pkg::FIELD_COORD_W;

    function automatic logic [CW-1:0] step_coord(input logic [CW-1:0] c, input logic dir);
        step_coord = dir ? c + CW'(1) : c - CW'(1);
    endfunction

    // Input fields.
    logic [FW-1:0]              in_x;
    logic [FW-1:0]              in_y;
    logic [FW-1:0]              in_z;
    logic [VW-1:0]              in_load;
    logic [swl_pkg::AXIS_W-1:0] in_axis;
    logic                       in_dir;
    logic [RW-1:0]              in_ra;
    logic [RW-1:0]              in_rb;

    assign in_x    = s_tdata[5:0];
    assign in_y    = s_tdata[11:6];
    assign in_z    = s_tdata[17:12];
    assign in_load = s_tdata[19:18];
    assign in_axis = s_tdata[21:20];
    assign in_dir  = s_tdata[22];
    assign in_ra   = s_tdata[38:23];
    assign in_rb   = s_tdata[54:39];

    // Site and neighbour addresses; coordinates wrap within the side.
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [CW-1:0] cz;
    logic [CW-1:0] nx;
    logic [CW-1:0] ny;
    logic [CW-1:0] nz;
    logic [AW-1:0] si_in;
    logic [AW-1:0] ni_in;

    assign cx = in_x[CW-1:0];
    assign cy = in_y[CW-1:0];
    assign cz = in_z[CW-1:0];

    always_comb
    begin
        nx = cx;
        ny = cy;
        nz = cz;
        unique case (in_axis)
            swl_pkg::AXIS_X: nx = step_coord(cx, in_dir);
            swl_pkg::AXIS_Y: ny = step_coord(cy, in_dir);
            default:         nz = step_coord(cz, in_dir);
        endcase
    end

    assign si_in = {cx, cy, cz};
    assign ni_in = {nx, ny, nz};

    // Item registers, captured when the request is accepted.
    logic [AW-1:0] si_reg;
    logic [AW-1:0] ni_reg;
    logic          kind_reg;
    logic [VW-1:0] load_reg;
    logic [RW-1:0] ra_reg;
    logic [RW-1:0] rb_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            si_reg   <= si_in;
            ni_reg   <= ni_in;
            kind_reg <= s_tuser;
            load_reg <= in_load;
            ra_reg   <= in_ra;
            rb_reg   <= in_rb;
        end
    end

    // Configuration registers.
    logic [PW-1:0] soil_prob_reg;
    logic [PW-1:0] death_prob_reg;
    logic [PW-1:0] repro_prob_reg;
    logic [PW-1:0] leave_prob_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soil_prob_reg  <= swl_pkg::SOIL_FILL_RESET;
            death_prob_reg <= swl_pkg::WORM_DEATH_RESET;
            repro_prob_reg <= swl_pkg::REPRODUCE_RESET;
            leave_prob_reg <= swl_pkg::NUTRIENT_LEAVE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                swl_pkg::CFG_SOIL_FILL:      soil_prob_reg  <= cfg_wdata;
                swl_pkg::CFG_WORM_DEATH:     death_prob_reg <= cfg_wdata;
                swl_pkg::CFG_REPRODUCE:      repro_prob_reg <= cfg_wdata;
                swl_pkg::CFG_NUTRIENT_LEAVE: leave_prob_reg <= cfg_wdata;
                default:                     soil_prob_reg  <= soil_prob_reg;
            endcase
        end
    end

    // Clearing sweep address.
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    assign status.clear_last = (clr_addr_reg == {AW{1'b1}});

    // Lattice memory: single port, one access per cycle, registered read.
    logic [VW-1:0] mem [swl_pkg::CELL_COUNT];
    logic [VW-1:0] rd_data_reg;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [VW-1:0] mem_wdata;

    // Decision registers: the site value is taken in the neighbour-read step, the rest in the evaluate step.
    logic [VW-1:0] sv_reg;
    logic          site_we_reg;
    logic [VW-1:0] site_val_reg;
    logic [VW-1:0] nb_after_reg;

    // Decision logic; the neighbour value is on the read register here.
    logic [VW-1:0] nv;
    logic          fill_hit;
    logic          death_hit;
    logic          repro_hit;
    logic          leave_hit;
    logic          nb_we;
    logic          site_we;
    logic [VW-1:0] site_val;

    assign nv        = rd_data_reg;
    assign fill_hit  = {1'b0, ra_reg} < soil_prob_reg;
    assign death_hit = {1'b0, ra_reg} < death_prob_reg;
    assign repro_hit = {1'b0, rb_reg} < repro_prob_reg;
    assign leave_hit = {1'b0, rb_reg} < leave_prob_reg;

    always_comb
    begin
        nb_we    = 1'b0;
        site_we  = 1'b0;
        site_val = swl_pkg::CELL_EMPTY;
        if (kind_reg == swl_pkg::CMD_LOAD)
        begin
            site_we  = 1'b1;
            site_val = load_reg;
        end
        else
        begin
            unique case (sv_reg)
                swl_pkg::CELL_EMPTY, swl_pkg::CELL_NUTRIENT:
                begin
                    site_we  = (nv == swl_pkg::CELL_SOIL) && fill_hit;
                    site_val = swl_pkg::CELL_SOIL;
                end
                swl_pkg::CELL_WORM:
                begin
                    site_we = 1'b1;
                    if (death_hit)
                    begin
                        site_val = swl_pkg::CELL_EMPTY;
                    end
                    else
                    begin
                        // The worm moves; pick what it leaves behind.
                        nb_we = 1'b1;
                        unique case (nv)
                            swl_pkg::CELL_NUTRIENT:
                                site_val = repro_hit ? swl_pkg::CELL_WORM
                                                     : swl_pkg::CELL_EMPTY;
                            swl_pkg::CELL_SOIL:
                                site_val = leave_hit ? swl_pkg::CELL_NUTRIENT
                                                     : swl_pkg::CELL_EMPTY;
                            swl_pkg::CELL_WORM:
                                site_val = swl_pkg::CELL_WORM;
                            default:
                                site_val = swl_pkg::CELL_EMPTY;
                        endcase
                    end
                end
                default:
                begin
                    site_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_nb)
        begin
            sv_reg <= rd_data_reg;
        end
        if (cmd.eval)
        begin
            site_we_reg  <= site_we;
            site_val_reg <= site_val;
            nb_after_reg <= nb_we ? swl_pkg::CELL_WORM : nv;
        end
    end

    // Memory port selection.
    always_comb
    begin
        mem_addr  = si_reg;
        mem_we    = 1'b0;
        mem_wdata = swl_pkg::CELL_EMPTY;
        priority if (cmd.clear_wr)
        begin
            mem_addr = clr_addr_reg;
            mem_we   = 1'b1;
        end
        else if (cmd.accept)
        begin
            mem_addr = si_in;
        end
        else if (cmd.rd_nb)
        begin
            mem_addr = ni_reg;
        end
        else if (cmd.eval)
        begin
            mem_addr  = ni_reg;
            mem_we    = nb_we;
            mem_wdata = swl_pkg::CELL_WORM;
        end
        else if (cmd.commit)
        begin
            mem_addr  = si_reg;
            mem_we    = site_we_reg;
            mem_wdata = site_val_reg;
        end
        else
        begin
            // Idle or waiting on the output: a harmless read of the site.
            mem_addr = si_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        else
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // Species counts: one cell change per cycle at most.
    logic [NW-1:0] cnt_reg  [swl_pkg::SPECIES];
    logic [NW-1:0] cnt_next [swl_pkg::SPECIES];
    logic          upd_en;
    logic [VW-1:0] upd_old;
    logic [VW-1:0] upd_new;

    always_comb
    begin
        upd_en  = 1'b0;
        upd_old = nv;
        upd_new = swl_pkg::CELL_WORM;
        if (cmd.eval)
        begin
            upd_en = nb_we;
        end
        else if (cmd.commit)
        begin
            upd_en  = site_we_reg;
            upd_old = sv_reg;
            upd_new = site_val_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < swl_pkg::SPECIES; i++)
        begin
            cnt_next[i] = cnt_reg[i]
                        + NW'(upd_en && (upd_new == VW'(i)))
                        - NW'(upd_en && (upd_old == VW'(i)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg[0] <= NW'(swl_pkg::CELL_COUNT);
            for (int i = 1; i < swl_pkg::SPECIES; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < swl_pkg::SPECIES; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // Output register; the result is loaded on the commit step.
    logic                           m_tvalid_reg;
    logic [swl_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic [VW-1:0]                  site_after;

    assign site_after      = site_we_reg ? site_val_reg : sv_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            m_tdata_reg <= {cnt_next[3], cnt_next[2], cnt_next[1], cnt_next[0],
                            nb_after_reg, site_after};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The four species always add up to the lattice size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[0] + cnt_reg[1] + cnt_reg[2] + cnt_reg[3]) == NW'(swl_pkg::CELL_COUNT))
        else $error("species counts do not add up to the lattice size");

    // A result is only committed into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_tvalid_reg || m_tready))
        else $error("result committed over a waiting result");

    // The neighbour is never the site itself.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |-> (ni_reg != si_reg))
        else $error("neighbour address equals site address");

endmodule

`default_nettype wire

/* design/soil_worm_lattice_update.sv */
// Stochastic soil and worm lattice update engine.
// Input stream (s_*): one request per item. s_tuser selects a load (0), which
// writes load_value into the site, or an update (1), which applies one
// stochastic step at the site and its named neighbour. Output stream (m_*):
// one result per request with the site and neighbour values after the step
// and the four running species counts.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 soil
// fill, 1 worm death, 2 reproduce, 3 nutrient leave); the user must write
// only while the engine idles; the block does not enforce this. Sequence: an
// item runs through steps set by the single-port lattice memory: a site
// read, a neighbour read, a neighbour write and a site write. The result is
// loaded into the output register with the site write, and the next request
// is accepted only after that, so the engine works on one item at a time.
// Reset: the counts reset at once; then a sweep clears the lattice, all
// 262144 cells, one cell per cycle, during which s_tready stays low.
// Stall: a result waits in the output register while m_tready is low; one
// more request is still accepted and processed, then holds before its site
// write until the output register frees.
`default_nettype none

module soil_worm_lattice_update (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0 up: site_x, site_y, site_z, load_value, axis,
    // direction, rand_a, rand_b, one zero pad bit.
    input  wire logic [swl_pkg::IN_DATA_W-1:0]     s_tdata,
    // Field: cmd.
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Fields from bit 0 up: site_after, neighbour_after, count_empty,
    // count_nutrient, count_soil, count_worm.
    output logic [swl_pkg::OUT_DATA_W-1:0]         m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [swl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [swl_pkg::PROB_W-1:0]        cfg_wdata
);

    swl_pkg::swl_cmd_t    cmd;
    swl_pkg::swl_status_t status;

    // Sequencer.
    swl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Lattice memory, decision logic, counts and output register.
    swl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

/* tb/swl_tb_pkg.sv */
`timescale 1ns / 1ps

package swl_tb_pkg;

    import swl_pkg::*;

    // Axis codes with no name in the design package; code three falls back to z.
    localparam logic [AXIS_W-1:0] AXIS_Z     = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_SPARE = 2'd3;

    // One request on s_tdata, first member in the top bits.
    typedef struct packed {
        logic                     pad;
        logic [RAND_W-1:0]        rand_b;
        logic [RAND_W-1:0]        rand_a;
        logic                     direction;
        logic [AXIS_W-1:0]        axis;
        logic [CELL_W-1:0]        load_value;
        logic [FIELD_COORD_W-1:0] site_z;
        logic [FIELD_COORD_W-1:0] site_y;
        logic [FIELD_COORD_W-1:0] site_x;
    } request_t;

    // One result on m_tdata, first member in the top bits.
    typedef struct packed {
        logic [COUNT_W-1:0] count_worm;
        logic [COUNT_W-1:0] count_soil;
        logic [COUNT_W-1:0] count_nutrient;
        logic [COUNT_W-1:0] count_empty;
        logic [CELL_W-1:0]  neighbour_after;
        logic [CELL_W-1:0]  site_after;
    } result_t;

endpackage

/* tb/soil_worm_checker.sv */
`timescale 1ns / 1ps

module soil_worm_checker
    import swl_pkg::*, swl_tb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_DATA_W-1:0]  m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PROB_W-1:0]      cfg_wdata,
    output int                     mismatch_count,
    output int                     outstanding,
    output int                     results_checked,
    output int                     soil_fills,
    output int                     worm_deaths,
    output int                     worm_moves
);

    // Shadow lattice and species tallies; the lattice starts all empty.
    bit [CELL_W-1:0] cells [CELL_COUNT];
    int unsigned     tally [SPECIES];

    // Shadow copy of the probability registers.
    logic [PROB_W-1:0] fill_prob;
    logic [PROB_W-1:0] death_prob;
    logic [PROB_W-1:0] reproduce_prob;
    logic [PROB_W-1:0] nutrient_prob;

    // Predicted cell values and counts, oldest first.
    result_t predicted_readouts [$];

    function automatic int unsigned wrap_step(int unsigned c, logic up);
        return up ? (c + 1) % SIDE : (c + SIDE - 1) % SIDE;
    endfunction

    function automatic void write_cell(int unsigned addr, logic [CELL_W-1:0] v);
        tally[cells[addr]] -= 1;
        tally[v] += 1;
        cells[addr] = v;
    endfunction

    // Applies one request to the shadow lattice and returns what the block should report.
    function automatic result_t advance_lattice(logic cmd, request_t req);
        int unsigned       x, y, z, nx, ny, nz, site, nb;
        logic [CELL_W-1:0] site_v, nb_v, left_behind;
        result_t           r;
        x  = req.site_x % SIDE;
        y  = req.site_y % SIDE;
        z  = req.site_z % SIDE;
        nx = x;
        ny = y;
        nz = z;
        if (req.axis == AXIS_X)
            nx = wrap_step(x, req.direction);
        else if (req.axis == AXIS_Y)
            ny = wrap_step(y, req.direction);
        else
            nz = wrap_step(z, req.direction);
        site   = (x * SIDE + y) * SIDE + z;
        nb     = (nx * SIDE + ny) * SIDE + nz;
        site_v = cells[site];
        nb_v   = cells[nb];

        if (cmd == CMD_LOAD) begin
            write_cell(site, req.load_value);
        end
        else if (site_v == CELL_EMPTY || site_v == CELL_NUTRIENT) begin
            // Soil spreads into an open site next to soil.
            if (nb_v == CELL_SOIL && req.rand_a < fill_prob) begin
                write_cell(site, CELL_SOIL);
                soil_fills++;
            end
        end
        else if (site_v == CELL_WORM) begin
            if (req.rand_a < death_prob) begin
                write_cell(site, CELL_EMPTY);
                worm_deaths++;
            end
            else begin
                // The worm moves; what stays behind depends on what it entered.
                left_behind = CELL_EMPTY;
                if (nb_v == CELL_NUTRIENT) begin
                    if (req.rand_b < reproduce_prob)
                        left_behind = CELL_WORM;
                end
                else if (nb_v == CELL_SOIL) begin
                    if (req.rand_b < nutrient_prob)
                        left_behind = CELL_NUTRIENT;
                end
                else if (nb_v == CELL_WORM) begin
                    left_behind = CELL_WORM;
                end
                write_cell(nb, CELL_WORM);
                write_cell(site, left_behind);
                worm_moves++;
            end
        end

        r.site_after      = cells[site];
        r.neighbour_after = cells[nb];
        r.count_empty     = COUNT_W'(tally[CELL_EMPTY]);
        r.count_nutrient  = COUNT_W'(tally[CELL_NUTRIENT]);
        r.count_soil      = COUNT_W'(tally[CELL_SOIL]);
        r.count_worm      = COUNT_W'(tally[CELL_WORM]);
        return r;
    endfunction

    function automatic void compare_field(string label, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endfunction

    // Watch both streams and the register port at each rising edge.
    always @(posedge clk or negedge rst_n) begin
        result_t got;
        result_t want;
        if (!rst_n) begin
            tally[CELL_EMPTY]    = CELL_COUNT;
            tally[CELL_NUTRIENT] = 0;
            tally[CELL_SOIL]     = 0;
            tally[CELL_WORM]     = 0;
            fill_prob            = SOIL_FILL_RESET;
            death_prob           = WORM_DEATH_RESET;
            reproduce_prob       = REPRODUCE_RESET;
            nutrient_prob        = NUTRIENT_LEAVE_RESET;
            predicted_readouts.delete();
            mismatch_count       = 0;
            results_checked      = 0;
            soil_fills           = 0;
            worm_deaths          = 0;
            worm_moves           = 0;
            outstanding         <= 0;
        end
        else begin
            // A result always belongs to a request taken at an earlier edge.
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_checked++;
                if (predicted_readouts.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with no request outstanding, expected none, actual %h",
                             $time, m_tdata);
                end
                else begin
                    want = predicted_readouts.pop_front();
                    compare_field("site_after", want.site_after, got.site_after);
                    compare_field("neighbour_after", want.neighbour_after,
                                  got.neighbour_after);
                    compare_field("count_empty", want.count_empty, got.count_empty);
                    compare_field("count_nutrient", want.count_nutrient, got.count_nutrient);
                    compare_field("count_soil", want.count_soil, got.count_soil);
                    compare_field("count_worm", want.count_worm, got.count_worm);
                end
            end

            if (s_tvalid && s_tready)
                predicted_readouts.push_back(advance_lattice(s_tuser, s_tdata));

            if (cfg_we) begin
                case (cfg_index)
                    CFG_SOIL_FILL:      fill_prob      = cfg_wdata;
                    CFG_WORM_DEATH:     death_prob     = cfg_wdata;
                    CFG_REPRODUCE:      reproduce_prob = cfg_wdata;
                    CFG_NUTRIENT_LEAVE: nutrient_prob  = cfg_wdata;
                    default:            ;
                endcase
            end

            outstanding <= predicted_readouts.size();
        end
    end

endmodule

/* tb/tb_soil_worm_lattice_update.sv */
`timescale 1ns / 1ps

module tb_soil_worm_lattice_update;

    import swl_pkg::*;
    import swl_tb_pkg::*;

    // The reset sweep alone clears all 262144 cells.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PROB_MAX    = 2 ** PROB_W - 1;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // Fields from bit 0 up: site_x, site_y, site_z, load_value, axis,
    // direction, rand_a, rand_b, pad.
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    // Field: cmd.
    logic                   s_tuser   = CMD_LOAD;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // Fields from bit 0 up: site_after, neighbour_after, count_empty,
    // count_nutrient, count_soil, count_worm.
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SOIL_FILL;
    logic [PROB_W-1:0]      cfg_wdata = '0;

    int mismatch_count;
    int outstanding;
    int results_checked;
    int soil_fills;
    int worm_deaths;
    int worm_moves;

    // Stimulus bookkeeping.
    int unsigned prob [SPECIES];
    int          loads_sent    = 0;
    int          updates_sent  = 0;
    int          settings_used = 1;
    int          cycle_count   = 0;
    int          hold_req      = 0;
    int          hold_done     = 0;
    logic        steady        = 1'b0;

    soil_worm_lattice_update u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    soil_worm_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .soil_fills      (soil_fills),
        .worm_deaths     (worm_deaths),
        .worm_moves      (worm_moves)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Receiver: random stalls, one long hold on request, none while steady.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_done != hold_req) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_done++;
            end
            m_tready <= steady || ($urandom_range(99) >= 22);
        end
    end

    // Offers one request and waits until the block takes it.
    task automatic send(logic cmd, request_t req);
        if (!steady) begin
            while ($urandom_range(99) < 22) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (cmd == CMD_LOAD)
            loads_sent++;
        else
            updates_sent++;
    endtask

    function automatic request_t random_fields();
        logic [63:0] raw;
        request_t    req;
        raw     = {$urandom, $urandom};
        req     = raw[IN_DATA_W-1:0];
        req.pad = 1'b0;
        return req;
    endfunction

    task automatic load_cell(int x, int y, int z, logic [CELL_W-1:0] v);
        request_t req;
        req            = random_fields();
        req.site_x     = FIELD_COORD_W'(x);
        req.site_y     = FIELD_COORD_W'(y);
        req.site_z     = FIELD_COORD_W'(z);
        req.load_value = v;
        send(CMD_LOAD, req);
    endtask

    task automatic step_site(int x, int y, int z, logic [AXIS_W-1:0] axis, logic up,
                             int ra, int rb);
        request_t req;
        req           = random_fields();
        req.site_x    = FIELD_COORD_W'(x);
        req.site_y    = FIELD_COORD_W'(y);
        req.site_z    = FIELD_COORD_W'(z);
        req.axis      = axis;
        req.direction = up;
        req.rand_a    = RAND_W'(ra);
        req.rand_b    = RAND_W'(rb);
        send(CMD_UPDATE, req);
    endtask

    // A draw just at or just under a probability, so both sides of the compare occur.
    function automatic logic [RAND_W-1:0] near_threshold(int unsigned p);
        int unsigned v;
        v = (p == 0) ? 0 : p - $urandom_range(1);
        return (v > 65535) ? 16'hFFFF : v[RAND_W-1:0];
    endfunction

    // Mostly a small cube of sites so loads and moves interact; the rest anywhere.
    task automatic random_request(int base);
        request_t req;
        logic     cmd;
        req = random_fields();
        if ($urandom_range(99) < 85) begin
            req.site_x = FIELD_COORD_W'((base + $urandom_range(3)) % SIDE);
            req.site_y = FIELD_COORD_W'((base + $urandom_range(3)) % SIDE);
            req.site_z = FIELD_COORD_W'((base + $urandom_range(3)) % SIDE);
        end
        cmd = ($urandom_range(99) < 35) ? CMD_LOAD : CMD_UPDATE;
        if (cmd == CMD_UPDATE && $urandom_range(99) < 25) begin
            req.rand_a = near_threshold($urandom_range(1) ? prob[CFG_SOIL_FILL]
                                                          : prob[CFG_WORM_DEATH]);
            req.rand_b = near_threshold($urandom_range(1) ? prob[CFG_REPRODUCE]
                                                          : prob[CFG_NUTRIENT_LEAVE]);
        end
        send(cmd, req);
    endtask

    task automatic run_phase(int count, int hold_at);
        int base;
        base = $urandom_range(1) ? SIDE - 2 : $urandom_range(SIDE - 1);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at)
                hold_req <= hold_req + 1;
            random_request(base);
        end
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v[PROB_W-1:0];
        prob[idx]  = v;
        @(posedge clk);
    endtask

    task automatic set_probs(int unsigned fill, int unsigned death, int unsigned repro,
                             int unsigned leave);
        drain();
        write_reg(CFG_SOIL_FILL, fill);
        write_reg(CFG_WORM_DEATH, death);
        write_reg(CFG_REPRODUCE, repro);
        write_reg(CFG_NUTRIENT_LEAVE, leave);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic int unsigned rand_prob();
        return ($urandom_range(99) < 10) ? $urandom_range(PROB_MAX, 65537)
                                         : $urandom_range(65536);
    endfunction

    initial begin
        prob[CFG_SOIL_FILL]      = SOIL_FILL_RESET;
        prob[CFG_WORM_DEATH]     = WORM_DEATH_RESET;
        prob[CFG_REPRODUCE]      = REPRODUCE_RESET;
        prob[CFG_NUTRIENT_LEAVE] = NUTRIENT_LEAVE_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed cases under the reset probabilities.
        load_cell(0, 0, 0, CELL_WORM);
        step_site(0, 0, 0, AXIS_X, 1'b0, 65535, 0);         // worm wraps to x 63
        load_cell(63, 63, 63, CELL_SOIL);
        step_site(63, 63, 63, AXIS_SPARE, 1'b1, 0, 0);      // soil site stays put
        load_cell(0, 0, 63, CELL_SOIL);
        step_site(0, 0, 62, AXIS_Z, 1'b1, 0, 0);            // empty site fills
        step_site(0, 0, 61, AXIS_Z, 1'b1, 65535, 0);        // draw too high
        load_cell(1, 0, 63, CELL_NUTRIENT);
        step_site(1, 0, 63, AXIS_X, 1'b0, 32768, 0);        // draw equals probability
        step_site(1, 0, 63, AXIS_X, 1'b0, 32767, 0);        // nutrient becomes soil
        step_site(2, 0, 0, AXIS_Y, 1'b0, 0, 0);             // neighbour not soil
        load_cell(5, 5, 5, CELL_WORM);
        step_site(5, 5, 5, AXIS_Y, 1'b0, 19660, 0);         // worm dies
        load_cell(5, 5, 5, CELL_WORM);
        step_site(5, 5, 5, AXIS_Y, 1'b0, 19661, 0);         // moves into empty
        load_cell(5, 3, 5, CELL_NUTRIENT);
        step_site(5, 4, 5, AXIS_Y, 1'b0, 65535, 65535);     // eats and reproduces
        load_cell(5, 2, 5, CELL_SOIL);
        step_site(5, 3, 5, AXIS_Y, 1'b0, 40000, 0);         // enters soil, leaves nutrient
        step_site(5, 2, 5, AXIS_Y, 1'b1, 40000, 0);         // back into the nutrient
        step_site(5, 4, 5, AXIS_Y, 1'b0, 65535, 0);         // into another worm
        load_cell(63, 10, 10, CELL_WORM);
        step_site(63, 10, 10, AXIS_X, 1'b1, 65535, 65535);  // wraps to x 0
        load_cell(0, 10, 10, CELL_EMPTY);
        step_site(10, 0, 10, AXIS_Y, 1'b0, 0, 65535);       // y wraps to 63

        // Random phases, first under the reset probabilities, then across settings with the extremes first.
        run_phase(95, -1);
        set_probs(0, 0, 0, 0);
        run_phase(100, -1);
        set_probs(65536, 65536, 65536, 65536);
        run_phase(100, 40);
        set_probs(PROB_MAX, PROB_MAX, PROB_MAX, PROB_MAX);
        steady <= 1'b1;
        run_phase(100, -1);
        steady <= 1'b0;
        set_probs(65535, 1, 32768, 1);
        run_phase(135, -1);
        repeat (4) begin
            set_probs(rand_prob(), rand_prob(), rand_prob(), rand_prob());
            run_phase(80, -1);
        end
        drain();

        $display("Run covered %0d loads and %0d updates under %0d probability settings;",
                 loads_sent, updates_sent, settings_used);
        $display("%0d results checked, with %0d soil fills, %0d worm deaths and %0d worm moves.",
                 results_checked, soil_fills, worm_deaths, worm_moves);
        if (mismatch_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
